// ----- sv/mlp_pkg.sv -----
// Package for the sigmoid network inference block.
// Holds size constants, command codes, register indexes and the sigmoid table.
// No dependencies.
package mlp_pkg;

  localparam int MAX_LAYERS = 3;
  localparam int MAX_WIDTH  = 16;

  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_BIAS   = 2'd1;
  localparam logic [1:0] CMD_ELEM   = 2'd2;

  localparam logic [2:0] REG_LAYERS = 3'd0;
  localparam logic [2:0] REG_WIDTH0 = 3'd1;
  localparam logic [2:0] REG_WIDTH3 = 3'd4;

  localparam int ACT_W = 13;
  localparam int VAL_W = 16;
  localparam int ACC_W = 48;

  // Restoring division, only evaluated while the table is elaborated.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= dvs) begin
        rem = rem - dvs;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid samples at x = (k-128)/16 in Q0.12, computed at elaboration
  // with the same integer recurrence used to define the table.
  function automatic logic [ACT_W-1:0] sig_entry(input logic [7:0] k);
    logic [63:0] p;
    logic [63:0] den;
    logic [63:0] res;
    int n;
    int target;
    p = 64'd1 << 30;
    target = (k >= 8'd128) ? (int'(k) - 128) : (128 - int'(k));
    for (n = 1; n <= 128; n++) begin
      if (n <= target) p = (p * 64'd1008687096 + (64'd1 << 29)) >> 30;
    end
    den = (64'd1 << 30) + p;
    if (k >= 8'd128) res = udiv64((64'd1 << 42) + (den >> 1), den);
    else res = udiv64((64'd4096 * p) + (den >> 1), den);
    return res[ACT_W-1:0];
  endfunction

endpackage

// ----- sv/mlp_sig_rom.sv -----
// Registered sigmoid lookup table, 256 entries of 13 bits.
// Depends on mlp_pkg for the table function.
module mlp_sig_rom (
  input  logic        clk,
  input  logic [7:0]  addr,
  output logic [12:0] data
);
  logic [12:0] rom [256];

  for (genvar g = 0; g < 256; g++) begin : g_rom
    localparam logic [12:0] ENTRY = mlp_pkg::sig_entry(8'(g));
    assign rom[g] = ENTRY;
  end

  always_ff @(posedge clk) begin
    data <= rom[addr];
  end
endmodule

// ----- sv/mlp_sigmoid_inference_top.sv -----
// Top level of the sigmoid network inference block.
// Holds weight, bias and activation memories, the MAC sequencer and APB regs.
// Depends on mlp_pkg and mlp_sig_rom.
//
// channel  | dir | signals                        | contents
// s_axis   | in  | tvalid tready tdata            | cmd layer row col value
// m_axis   | out | tvalid tready tdata tlast      | index activation
// apb      | in  | psel penable pwrite paddr ...  | layer_count width0..width3
//
// Loads and non-final elements are taken one per cycle, back to back, while idle.
// A final element starts a run over the layers: per row one bias read, win MAC
// steps and then the pipeline drain, the table lookup and the write-back, with
// the single MAC reading one weight per cycle from the weight memory. Output
// reads each result from the activation memory and stalls while m_axis_tready is
// low. Reset returns control to idle and the APB registers to defaults only;
// memories are undefined until written. No item is taken during a run or output.
module mlp_sigmoid_inference_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // cmd[1:0] layer[3:2] row[7:4] col[11:8] value[27:12]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // index[3:0] activation[16:4]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int MAX_LAYERS = mlp_pkg::MAX_LAYERS;
  localparam int MAX_WIDTH  = mlp_pkg::MAX_WIDTH;
  localparam int WB = $clog2(MAX_WIDTH);
  localparam int LB = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int CW = WB + 1;
  localparam int WDEPTH = MAX_LAYERS * MAX_WIDTH * MAX_WIDTH;
  localparam int BDEPTH = MAX_LAYERS * MAX_WIDTH;
  localparam int WA = $clog2(WDEPTH);
  localparam int BA = $clog2(BDEPTH);
  localparam int AA = WB + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROW  = 3'd1;  // issue bias read
  localparam logic [2:0] ST_MAC  = 3'd2;  // one product per cycle
  localparam logic [2:0] ST_FIN  = 3'd3;  // saturate, table lookup
  localparam logic [2:0] ST_WR   = 3'd4;  // write activation
  localparam logic [2:0] ST_OUTR = 3'd5;  // read activation for output
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [1:0] layer_count;
  logic [4:0] width_reg [4];
  logic [2:0] state;

  logic [1:0]  in_cmd;
  logic [1:0]  in_layer;
  logic [3:0]  in_row, in_col;
  logic [15:0] in_value;
  assign in_cmd   = s_axis_tdata[1:0];
  assign in_layer = s_axis_tdata[3:2];
  assign in_row   = s_axis_tdata[7:4];
  assign in_col   = s_axis_tdata[11:8];
  assign in_value = s_axis_tdata[27:12];

  assign pready = 1'b1;
  logic [2:0] reg_idx;
  assign reg_idx = paddr[4:2];
  always_comb begin
    prdata = '0;
    if (reg_idx == mlp_pkg::REG_LAYERS) prdata = {30'd0, layer_count};
    else if (reg_idx >= mlp_pkg::REG_WIDTH0 && reg_idx <= mlp_pkg::REG_WIDTH3)
      prdata = {27'd0, width_reg[2'(reg_idx - 3'd1)]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count <= 2'd1;
      for (int i = 0; i < 4; i++) width_reg[i] <= 5'd16;
    end else if (psel && penable && pwrite) begin
      if (reg_idx == mlp_pkg::REG_LAYERS) layer_count <= pwdata[1:0];
      else if (reg_idx >= mlp_pkg::REG_WIDTH0 && reg_idx <= mlp_pkg::REG_WIDTH3)
        width_reg[2'(reg_idx - 3'd1)] <= pwdata[4:0];
    end
  end

  function automatic logic [CW-1:0] eff_w(input logic [4:0] w);
    if (w == 5'd0) return CW'(1);
    if (32'(w) > MAX_WIDTH) return CW'(MAX_WIDTH);
    return CW'(w);
  endfunction

  logic [LB:0] eff_layers;
  always_comb begin
    if (layer_count == 2'd0) eff_layers = (LB+1)'(1);
    else if (32'(layer_count) > MAX_LAYERS) eff_layers = (LB+1)'(MAX_LAYERS);
    else eff_layers = (LB+1)'(layer_count);
  end

  // Sequencer registers
  localparam int ACC_W_L = mlp_pkg::ACC_W;
  logic [LB:0]  k;
  logic [CW-1:0] r, c;
  logic [CW-1:0] win, wout;
  logic signed [ACC_W_L-1:0] acc;
  logic mac_v;       // read data valid for product this cycle
  logic bias_v;

  logic s_fire;
  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // Memories
  logic signed [15:0] wmem [WDEPTH];
  logic signed [15:0] bmem [BDEPTH];
  logic signed [15:0] amem [2*MAX_WIDTH];
  logic signed [15:0] w_q, b_q, a_q;
  logic [WA-1:0] w_ra;
  logic [BA-1:0] b_ra;
  logic [AA-1:0] a_ra, a_wa;
  logic a_we;
  logic [15:0] a_wd;

  logic load_ok_w, load_ok_b;
  assign load_ok_w = s_fire && in_cmd == mlp_pkg::CMD_WEIGHT &&
                     32'(in_layer) < MAX_LAYERS && 32'(in_row) < MAX_WIDTH &&
                     32'(in_col) < MAX_WIDTH;
  assign load_ok_b = s_fire && in_cmd == mlp_pkg::CMD_BIAS &&
                     32'(in_layer) < MAX_LAYERS && 32'(in_row) < MAX_WIDTH;
  logic elem_ok, elem_last;
  logic [CW-1:0] w0;
  assign w0 = eff_w(width_reg[0]);
  assign elem_ok = s_fire && in_cmd == mlp_pkg::CMD_ELEM && CW'(in_col) < w0;
  assign elem_last = elem_ok && CW'(in_col) == w0 - CW'(1);

  always_ff @(posedge clk) begin
    if (load_ok_w)
      wmem[WA'((32'(in_layer) * MAX_WIDTH + 32'(in_row)) * MAX_WIDTH + 32'(in_col))]
        <= in_value;
    w_q <= wmem[w_ra];
  end
  always_ff @(posedge clk) begin
    if (load_ok_b) bmem[BA'(32'(in_layer) * MAX_WIDTH + 32'(in_row))] <= in_value;
    b_q <= bmem[b_ra];
  end
  always_ff @(posedge clk) begin
    if (a_we) amem[a_wa] <= a_wd;
    a_q <= amem[a_ra];
  end

  logic [7:0]  sig_addr;
  logic [12:0] sig_q;
  mlp_sig_rom u_rom (.clk(clk), .addr(sig_addr), .data(sig_q));

  assign w_ra = WA'((32'(k) * MAX_WIDTH + 32'(r[WB-1:0])) * MAX_WIDTH + 32'(c[WB-1:0]));
  assign b_ra = BA'(32'(k) * MAX_WIDTH + 32'(r[WB-1:0]));
  always_comb begin
    if (state == ST_OUTR || state == ST_OUT)
      a_ra = {k[0], r[WB-1:0]};
    else
      a_ra = {k[0], c[WB-1:0]};
  end

  always_comb begin
    a_we = 1'b0;
    a_wa = {1'b0, in_col[WB-1:0]};
    a_wd = in_value;
    if (elem_ok) a_we = 1'b1;
    else if (state == ST_WR) begin
      a_we = 1'b1;
      a_wa = {~k[0], r[WB-1:0]};
      a_wd = {3'd0, sig_q};
    end
  end

  // Floor to Q4.12 and saturate
  logic signed [ACC_W_L-13:0] zf;
  logic signed [15:0] z;
  assign zf = acc[ACC_W_L-1:12];
  always_comb begin
    if (zf > 36'sd32767) z = 16'sh7FFF;
    else if (zf < -36'sd32768) z = 16'sh8000;
    else z = zf[15:0];
  end
  assign sig_addr = 8'((z ^ 16'sh8000) >> 8);

  logic signed [31:0] prod;
  always_ff @(posedge clk) prod <= w_q * a_q;
  logic prod_v;

  logic [CW-1:0] nout;
  logic fin_wait;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k <= '0; r <= '0; c <= '0;
      mac_v <= 1'b0; prod_v <= 1'b0; bias_v <= 1'b0; fin_wait <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      prod_v <= mac_v;
      mac_v <= 1'b0;
      bias_v <= 1'b0;
      if (bias_v) acc <= ACC_W_L'(b_q) <<< 12;
      else if (prod_v) acc <= acc + ACC_W_L'(prod);
      case (state)
        ST_IDLE: begin
          if (elem_last) begin
            k <= '0; r <= '0; c <= '0;
            win <= w0;
            wout <= eff_w(width_reg[1]);
            state <= ST_ROW;
          end
        end
        ST_ROW: begin
          bias_v <= 1'b1;
          c <= '0;
          state <= ST_MAC;
        end
        ST_MAC: begin
          mac_v <= 1'b1;
          if (c == win - CW'(1)) begin
            state <= ST_FIN;
            fin_wait <= 1'b0;
          end else c <= c + CW'(1);
        end
        ST_FIN: begin
          // wait for the last product to land, then table read
          if (!mac_v && !prod_v) begin
            if (fin_wait) state <= ST_WR;
            fin_wait <= 1'b1;
          end
        end
        ST_WR: begin
          if (r == wout - CW'(1)) begin
            r <= '0;
            if (k + (LB+1)'(1) == eff_layers) begin
              k <= k + (LB+1)'(1);
              nout <= wout;
              state <= ST_OUTR;
            end else begin
              k <= k + (LB+1)'(1);
              win <= wout;
              wout <= eff_w(width_reg[2'(k + (LB+1)'(2))]);
              state <= ST_ROW;
            end
          end else begin
            r <= r + CW'(1);
            state <= ST_ROW;
          end
        end
        ST_OUTR: begin
          state <= ST_OUT;
          m_axis_tvalid <= 1'b0;
        end
        ST_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= {7'd0, a_q[12:0], 4'(r)};
            m_axis_tlast <= (r == nout - CW'(1));
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (m_axis_tlast) state <= ST_IDLE;
            else begin
              r <= r + CW'(1);
              state <= ST_OUTR;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid) else $error("input ready while output pending");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("run did not end after last item");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_axis_tready) else $error("accepting while busy");
endmodule
